// ===== src/nec_pkg.sv =====
// package for the nfa epsilon closure block
// field widths, command and status codes, beat structs; no dependencies
`timescale 1ns / 1ps

package nec_pkg;

    localparam int STATE_W    = 5;
    localparam int SYM_W      = 8;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int COUNT_CFG_W = 6;
    localparam int STATE_LIMIT = 32;

    localparam int DEF_MAX_STATES = 32;
    localparam int DEF_MAX_LINKS  = 32;

    localparam logic [COUNT_CFG_W-1:0] RESET_STATE_COUNT = 6'd32;
    localparam logic [SYM_W-1:0]       RESET_EPSILON     = 8'd101;

    // command codes
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON     = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [STATE_W-1:0] from_state;
        logic [STATE_W-1:0] to_state;
        logic [SYM_W-1:0]   edge_symbol;
    } nec_cmd_t;

    typedef struct packed {
        logic [STATE_W-1:0]  closure_state;
        logic                last;
        logic [STATUS_W-1:0] status;
    } nec_result_t;

    // request from the walker to the edge store
    typedef struct packed {
        logic               add;
        logic               clr;
        logic               rd;
        logic [STATE_W-1:0] state;
        logic [STATE_W-1:0] target;
    } nec_ctl_t;

endpackage

// ===== src/nec_edge_store.sv =====
// edge store: per-state edge counters in flops and the edge target memory
// depends on nec_pkg
`timescale 1ns / 1ps

module nec_edge_store #(
    parameter int MAX_STATES = nec_pkg::DEF_MAX_STATES,
    parameter int MAX_LINKS  = nec_pkg::DEF_MAX_LINKS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  nec_pkg::nec_ctl_t                      ctl,
    input  logic [$clog2(MAX_LINKS+1)-1:0]         rd_pos,
    output logic [$clog2(MAX_LINKS+1)-1:0]         count,
    output logic [nec_pkg::STATE_W-1:0]            rd_target
);
    import nec_pkg::*;

    localparam int USED    = (MAX_STATES < STATE_LIMIT) ? MAX_STATES : STATE_LIMIT;
    localparam int SIW     = $clog2(USED);
    localparam int CW      = $clog2(MAX_LINKS+1);
    localparam int ENTRIES = USED * MAX_LINKS;
    localparam int AW      = $clog2(ENTRIES);

    logic [CW-1:0]      count_reg [2**SIW];
    logic [STATE_W-1:0] target_mem [ENTRIES];
    logic [STATE_W-1:0] rd_target_reg;

    logic [SIW-1:0] sidx;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;

    assign sidx    = ctl.state[SIW-1:0];
    assign count   = count_reg[sidx];
    assign wr_addr = AW'(sidx) * AW'(MAX_LINKS) + AW'(count);
    assign rd_addr = AW'(sidx) * AW'(MAX_LINKS) + AW'(rd_pos);

    // edge counters, cleared as a whole
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2**SIW; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (ctl.clr)
        begin
            for (int i = 0; i < 2**SIW; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (ctl.add)
        begin
            count_reg[sidx] <= count + CW'(1);
        end
    end

    // edge target memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (ctl.add)
        begin
            target_mem[wr_addr] <= ctl.target;
        end
        if (ctl.rd)
        begin
            rd_target_reg <= target_mem[rd_addr];
        end
    end

    assign rd_target = rd_target_reg;

endmodule

// ===== src/nfa_epsilon_closure.sv =====
// top level: command decode, depth-first closure walk with a stack memory
// depends on nec_pkg and nec_edge_store
//
//   channel   ports                        direction  handshake
//   command   start, busy, cmd             in         start && !busy
//   result    result_strobe, result        out        one cycle, no stall
//   config    cfg_we, cfg_index, cfg_data  in         cfg_we
//
// add edge and clear: result beat the cycle after the command, busy stays low
// query: busy from the cycle after the command; each epsilon edge examined
//   takes a fetch and a check, each state popped back to its parent a fetch
//   and a pop, and the walk ends with one more fetch
// reset clears counters and control and sets config to its defaults; memories hold no reset
// the receiver cannot stall; each query beat is held until the next state is
//   found so the final one can carry last, and goes out as busy drops
`timescale 1ns / 1ps

module nfa_epsilon_closure #(
    parameter int MAX_STATES = nec_pkg::DEF_MAX_STATES,
    parameter int MAX_LINKS  = nec_pkg::DEF_MAX_LINKS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  nec_pkg::nec_cmd_t                cmd,
    output logic                             result_strobe,
    output nec_pkg::nec_result_t             result,
    input  logic                             cfg_we,
    input  logic [nec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nec_pkg::CFG_W-1:0]        cfg_data
);
    import nec_pkg::*;

    localparam int CW   = $clog2(MAX_LINKS+1);
    localparam int SE_W = STATE_W + CW;
    localparam int SPW  = $clog2(STATE_LIMIT);
    localparam logic [6:0] MAX_STATES_V = 7'(MAX_STATES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_POP
    } fsm_t;

    fsm_t fsm_reg, fsm_next;

    logic [COUNT_CFG_W-1:0] state_count_reg;
    logic [SYM_W-1:0]       epsilon_reg;

    logic [STATE_W-1:0]     cur_s_reg, cur_s_next;
    logic [CW-1:0]          cur_p_reg, cur_p_next;
    logic [SPW:0]           sp_reg, sp_next;
    logic [STATE_LIMIT-1:0] visited_reg, visited_next;
    logic [STATE_W-1:0]     pend_reg, pend_next;
    logic                   strobe_reg, strobe_next;
    nec_result_t            result_reg, result_next;

    logic [SE_W-1:0] stack_mem [STATE_LIMIT];
    logic [SE_W-1:0] stack_rd_reg;
    logic            stack_we;
    logic            stack_re;
    logic [SPW-1:0]  stack_waddr;
    logic [SPW-1:0]  stack_raddr;

    nec_ctl_t           ctl;
    logic [CW-1:0]      count;
    logic [STATE_W-1:0] edge_data;
    logic               from_ok;
    logic               to_ok;

    nec_edge_store #(
        .MAX_STATES (MAX_STATES),
        .MAX_LINKS  (MAX_LINKS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .rd_pos    (cur_p_reg),
        .count     (count),
        .rd_target (edge_data)
    );

    assign busy          = (fsm_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // state validity against config and storage size
    assign from_ok = ({1'b0, cmd.from_state} < state_count_reg)
                  && ({2'b0, cmd.from_state} < MAX_STATES_V);
    assign to_ok   = ({1'b0, cmd.to_state} < state_count_reg)
                  && ({2'b0, cmd.to_state} < MAX_STATES_V);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_count_reg <= RESET_STATE_COUNT;
            epsilon_reg     <= RESET_EPSILON;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STATE_COUNT: state_count_reg <= cfg_data[COUNT_CFG_W-1:0];
                CFG_EPSILON:     epsilon_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // command decode and walk sequencing
    always_comb
    begin
        fsm_next     = fsm_reg;
        cur_s_next   = cur_s_reg;
        cur_p_next   = cur_p_reg;
        sp_next      = sp_reg;
        visited_next = visited_reg;
        pend_next    = pend_reg;
        strobe_next  = 1'b0;
        result_next  = result_reg;
        stack_we     = 1'b0;
        stack_re     = 1'b0;
        stack_waddr  = sp_reg[SPW-1:0];
        stack_raddr  = sp_reg[SPW-1:0] - SPW'(1);
        ctl          = '0;
        ctl.state    = busy ? cur_s_reg : cmd.from_state;
        ctl.target   = cmd.to_state;

        case (fsm_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.mode)
                        MODE_ADD:
                        begin
                            strobe_next = 1'b1;
                            result_next = '{closure_state: '0, last: 1'b1, status: ST_OK};
                            if (!from_ok || !to_ok)
                            begin
                                result_next.status = ST_RANGE;
                            end
                            else if (cmd.edge_symbol == epsilon_reg)
                            begin
                                if (count == CW'(MAX_LINKS))
                                begin
                                    result_next.status = ST_FULL;
                                end
                                else
                                begin
                                    ctl.add = 1'b1;
                                end
                            end
                        end
                        MODE_CLEAR:
                        begin
                            ctl.clr     = 1'b1;
                            strobe_next = 1'b1;
                            result_next = '{closure_state: '0, last: 1'b1, status: ST_OK};
                        end
                        MODE_QUERY:
                        begin
                            if (!from_ok)
                            begin
                                strobe_next = 1'b1;
                                result_next = '{closure_state: '0, last: 1'b1,
                                                status: ST_RANGE};
                            end
                            else
                            begin
                                visited_next = '0;
                                visited_next[cmd.from_state] = 1'b1;
                                pend_next  = cmd.from_state;
                                cur_s_next = cmd.from_state;
                                cur_p_next = '0;
                                sp_next    = '0;
                                fsm_next   = S_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH:
            begin
                if (cur_p_reg >= count)
                begin
                    if (sp_reg == '0)
                    begin
                        // walk done: flush the held beat as the last one
                        strobe_next = 1'b1;
                        result_next = '{closure_state: pend_reg, last: 1'b1, status: ST_OK};
                        fsm_next    = S_IDLE;
                    end
                    else
                    begin
                        stack_re = 1'b1;
                        sp_next  = sp_reg - (SPW+1)'(1);
                        fsm_next = S_POP;
                    end
                end
                else
                begin
                    ctl.rd     = 1'b1;
                    cur_p_next = cur_p_reg + CW'(1);
                    fsm_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                fsm_next = S_FETCH;
                if (!visited_reg[edge_data])
                begin
                    // new state: emit the held beat, descend into the target
                    visited_next[edge_data] = 1'b1;
                    strobe_next = 1'b1;
                    result_next = '{closure_state: pend_reg, last: 1'b0, status: ST_OK};
                    pend_next   = edge_data;
                    stack_we    = 1'b1;
                    sp_next     = sp_reg + (SPW+1)'(1);
                    cur_s_next  = edge_data;
                    cur_p_next  = '0;
                end
            end
            S_POP:
            begin
                cur_s_next = stack_rd_reg[SE_W-1:CW];
                cur_p_next = stack_rd_reg[CW-1:0];
                fsm_next   = S_FETCH;
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg     <= S_IDLE;
            cur_s_reg   <= '0;
            cur_p_reg   <= '0;
            sp_reg      <= '0;
            visited_reg <= '0;
            pend_reg    <= '0;
            strobe_reg  <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            fsm_reg     <= fsm_next;
            cur_s_reg   <= cur_s_next;
            cur_p_reg   <= cur_p_next;
            sp_reg      <= sp_next;
            visited_reg <= visited_next;
            pend_reg    <= pend_next;
            strobe_reg  <= strobe_next;
            result_reg  <= result_next;
        end
    end

    // walk stack memory, saves the parent state and its next edge position
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= {cur_s_reg, cur_p_reg};
        end
        if (stack_re)
        begin
            stack_rd_reg <= stack_mem[stack_raddr];
        end
    end

    // error beats are always single and carry no state
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.status != ST_OK) |-> (result.last && result.closure_state == '0))
        else $error("error beat not single");

    // a beat that is not the last comes only from a running walk
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last) |-> busy)
        else $error("intermediate beat outside a walk");

    // the stack never grows past the state limit
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg < (SPW+1)'(STATE_LIMIT))
        else $error("walk stack overflow");

    // a newly found state is marked visited right after
    a_visit_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == S_CHECK && !visited_reg[edge_data]) |=> visited_reg[$past(edge_data)])
        else $error("new state not marked visited");

endmodule
